// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files, included by pjtp_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, and switched off while reset is held.
`define PJTP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pjtp assertion failed");

// Checked on every rising clock edge, also while reset is held.
`define PJTP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pjtp assertion failed");

`endif

// File: hw/rtl/pjtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjtp_pkg
// Types, codes and the exp(-2^k) table of the jump transition probability block.
// ----------------------------------------------------------------------------
package pjtp_pkg;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_OBSERVE = 1'b1;

  localparam logic REG_DELTA  = 1'b0;
  localparam logic REG_STATES = 1'b1;

  localparam logic [19:0] XMAX = 20'hFFFFF;
  localparam int          MAX_RESULTS = 8;

  typedef enum logic [1:0] {
    JS_ZERO,
    JS_POS,
    JS_NEG
  } jsign_e;

  // One queued word. For a load, a/b/c are base, slope and threshold;
  // for an observation, a is the observed level.
  typedef struct packed {
    logic        cmd;
    logic [2:0]  idx;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    jsign_e      jsign;
    logic [3:0]  cnt;
  } item_t;

  // exp(-2^(b-16)) in Q0.32.
  function automatic logic [31:0] exp_coef(input logic [4:0] b);
    logic [31:0] c;
    case (b)
      5'd0:    c = 32'd4294901760;
      5'd1:    c = 32'd4294836226;
      5'd2:    c = 32'd4294705160;
      5'd3:    c = 32'd4294443040;
      5'd4:    c = 32'd4293918848;
      5'd5:    c = 32'd4292870656;
      5'd6:    c = 32'd4290775039;
      5'd7:    c = 32'd4286586875;
      5'd8:    c = 32'd4278222805;
      5'd9:    c = 32'd4261543595;
      5'd10:   c = 32'd4228380000;
      5'd11:   c = 32'd4162825044;
      5'd12:   c = 32'd4034748383;
      5'd13:   c = 32'd3790295335;
      5'd14:   c = 32'd3344923893;
      5'd15:   c = 32'd2605029347;
      5'd16:   c = 32'd1580030169;
      5'd17:   c = 32'd581260616;
      5'd18:   c = 32'd78665070;
      5'd19:   c = 32'd1440801;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/poisson_jump_transition_prob.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poisson_jump_transition_prob
// Jump transition probabilities of a Poisson jump model over hidden states.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis; tuser[0] is the command (0 load, 1 observe).
// A load writes one state's base rate, slope and threshold; it gives no result.
// An observe word gives one result word per state in use on m_axis, states in
// order, with tlast on the last one.
// Each state passes through the shared datapath: a table read, then for
// each jump direction a distance, two multiplies, a 20-step exp(-x) iteration
// and a probability step, then one product and the output step. A two-word
// queue lets s_axis take further words while the datapath is busy, and the
// output register holds a result while m_axis stalls; the datapath then waits
// in its output step until the result is taken.
// Reset clears the tables (through valid bits, at once), sets delta to 1.0 and
// states in use to 8. Registers are written over cfg_*; the user must write
// them only while the block is idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module poisson_jump_transition_prob
  import pjtp_pkg::*;
#(
  parameter int STATES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // state_index[2:0], rate_base[34:3], rate_slope[66:35],
  // level_threshold[98:67], observed_level[130:99], jump_value[162:131]
  input  logic [167:0] s_axis_tdata,
  // command[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_state[2:0], probability[19:3]
  output logic [23:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int DEPTH = (STATES < MAX_RESULTS) ? STATES : MAX_RESULTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0] delta_q;
  logic [3:0]  siu_q;
  item_t       f_item, q_item;
  logic        q_full, q_empty, q_pop, push;
  logic [2:0]  m_state;
  logic [16:0] m_prob;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= 32'h00010000;
      siu_q   <= 4'd8;
    end else if (cfg_we_i) begin
      if (cfg_addr_i[0] == REG_DELTA) begin
        delta_q <= cfg_wdata_i;
      end else begin
        siu_q <= cfg_wdata_i[3:0];
      end
    end
  end

  pjtp_front #(.DEPTH(DEPTH)) u_front (
    .cmd_i           (s_axis_tuser[0]),
    .idx_i           (s_axis_tdata[2:0]),
    .base_i          (s_axis_tdata[34:3]),
    .slope_i         (s_axis_tdata[66:35]),
    .thr_i           (s_axis_tdata[98:67]),
    .level_i         (s_axis_tdata[130:99]),
    .jump_i          (s_axis_tdata[162:131]),
    .states_in_use_i (siu_q),
    .item_o          (f_item)
  );

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  pjtp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .dout_o  (q_item)
  );

  pjtp_back #(.DEPTH(DEPTH), .AW(AW)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .delta_i   (delta_q),
    .q_empty_i (q_empty),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_state_o (m_state),
    .m_prob_o  (m_prob),
    .m_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, m_prob, m_state};

endmodule

// File: hw/rtl/pjtp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjtp_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module pjtp_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/pjtp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjtp_front
// Classifies an incoming word: jump sign, clamped state count, queue format.
// ----------------------------------------------------------------------------
module pjtp_front
  import pjtp_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic        cmd_i,
  input  logic [2:0]  idx_i,
  input  logic [31:0] base_i,
  input  logic [31:0] slope_i,
  input  logic [31:0] thr_i,
  input  logic [31:0] level_i,
  input  logic [31:0] jump_i,
  input  logic [3:0]  states_in_use_i,
  output item_t       item_o
);

  localparam logic [3:0] CAP = 4'(DEPTH);

  logic [3:0] cnt;
  jsign_e     js;

  always_comb begin
    if (states_in_use_i == 4'd0) begin
      cnt = 4'd1;
    end else if (states_in_use_i > CAP) begin
      cnt = CAP;
    end else begin
      cnt = states_in_use_i;
    end
    if (jump_i[31]) begin
      js = JS_NEG;
    end else if (jump_i != 32'd0) begin
      js = JS_POS;
    end else begin
      js = JS_ZERO;
    end
  end

  always_comb begin
    item_o.cmd   = cmd_i;
    item_o.idx   = idx_i;
    item_o.a     = (cmd_i == CMD_LOAD) ? base_i : level_i;
    item_o.b     = slope_i;
    item_o.c     = thr_i;
    item_o.jsign = js;
    item_o.cnt   = cnt;
  end

endmodule

// File: hw/rtl/pjtp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjtp_queue
// Two-entry queue between the front and the back of the block.
// ----------------------------------------------------------------------------
module pjtp_queue
  import pjtp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t din_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t dout_o
);

  item_t      ent_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= din_i;
    end
  end

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign dout_o  = ent_q[rp_q];

endmodule

// File: hw/rtl/pjtp_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pjtp_back
// Table store and sequencer: one shared datapath computes both jump
// probabilities of each state and a product from them, one state after another.
// ----------------------------------------------------------------------------
module pjtp_back
  import pjtp_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] delta_i,
  input  logic        q_empty_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [2:0]  m_state_o,
  output logic [16:0] m_prob_o,
  output logic        m_last_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_DIST = 4'd2;
  localparam logic [3:0] S_MUL1 = 4'd3;
  localparam logic [3:0] S_INT  = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_EXP  = 4'd6;
  localparam logic [3:0] S_PROB = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]  st_q, st_d;
  logic [3:0]  idx_q, idx_d;
  logic        dir_q, dir_d;
  logic [4:0]  bit_q, bit_d;
  logic [DEPTH-1:0] valid_q, valid_d;
  logic        rvalid_q, rvalid_d;
  logic        ovalid_q, ovalid_d;

  logic [31:0] level_q, level_d;
  jsign_e      js_q, js_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] dist_q, dist_d;
  logic [63:0] prod_q, prod_d;
  logic [31:0] inten_q, inten_d;
  logic [19:0] x_q, x_d;
  logic [32:0] acc_q, acc_d;
  logic [16:0] p1_q, p1_d, p2_q, p2_d;
  logic [16:0] res_q, res_d;
  logic [2:0]  ostate_q, ostate_d;
  logic [16:0] oprob_q, oprob_d;
  logic        olast_q, olast_d;

  logic        ram_we, ram_re;
  logic [95:0] ram_rdata, ent;
  logic [31:0] e_base, e_slope, e_thr;
  logic [32:0] diff;
  logic [48:0] isum;
  logic [63:0] dprod;
  logic [64:0] eprod;
  logic [33:0] eround;
  logic [16:0] fa, fb;
  logic [33:0] fprod;
  logic        load_ok;

  pjtp_ram #(.WIDTH(96), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_item_i.idx[AW-1:0]),
    .wdata_i ({q_item_i.c, q_item_i.b, q_item_i.a}),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // An entry never loaded since reset reads as zero.
  assign ent     = rvalid_q ? ram_rdata : 96'd0;
  assign e_base  = ent[31:0];
  assign e_slope = ent[63:32];
  assign e_thr   = ent[95:64];

  assign load_ok = ({1'b0, q_item_i.idx} < 4'(DEPTH));

  always_comb begin
    st_d     = st_q;
    idx_d    = idx_q;
    dir_d    = dir_q;
    bit_d    = bit_q;
    valid_d  = valid_q;
    rvalid_d = rvalid_q;
    level_d  = level_q;
    js_d     = js_q;
    cnt_d    = cnt_q;
    dist_d   = dist_q;
    prod_d   = prod_q;
    inten_d  = inten_q;
    x_d      = x_q;
    acc_d    = acc_q;
    p1_d     = p1_q;
    p2_d     = p2_q;
    res_d    = res_q;
    ostate_d = ostate_q;
    oprob_d  = oprob_q;
    olast_d  = olast_q;
    ovalid_d = (ovalid_q && m_ready_i) ? 1'b0 : ovalid_q;
    q_pop_o  = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;

    diff = dir_q ? ($signed({level_q[31], level_q}) - $signed({e_thr[31], e_thr}))
                 : ($signed({e_thr[31], e_thr}) - $signed({level_q[31], level_q}));
    isum   = {17'd0, e_base} + {1'b0, prod_q[63:16]};
    dprod  = delta_i * inten_q;
    eprod  = acc_q * exp_coef(bit_q) + 65'h80000000;
    eround = {1'b0, acc_q} + 34'h8000;
    case (js_q)
      JS_POS: begin
        fa = p1_q;
        fb = 17'h10000 - p2_q;
      end
      JS_NEG: begin
        fa = p2_q;
        fb = 17'h10000 - p1_q;
      end
      default: begin
        fa = 17'h10000 - p1_q;
        fb = 17'h10000 - p2_q;
      end
    endcase
    fprod = fa * fb + 34'h8000;

    case (st_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.cmd == CMD_LOAD) begin
            if (load_ok) begin
              ram_we = 1'b1;
              valid_d[q_item_i.idx[AW-1:0]] = 1'b1;
            end
          end else begin
            level_d = q_item_i.a;
            js_d    = q_item_i.jsign;
            cnt_d   = q_item_i.cnt;
            idx_d   = 4'd0;
            st_d    = S_READ;
          end
        end
      end
      S_READ: begin
        ram_re   = 1'b1;
        rvalid_d = valid_q[idx_q[AW-1:0]];
        dir_d    = 1'b0;
        st_d     = S_DIST;
      end
      S_DIST: begin
        dist_d = diff[32] ? 32'd0 : diff[31:0];
        st_d   = S_MUL1;
      end
      S_MUL1: begin
        prod_d = e_slope * dist_q;
        st_d   = S_INT;
      end
      S_INT: begin
        inten_d = (|isum[48:32]) ? 32'hFFFFFFFF : isum[31:0];
        st_d    = S_MUL2;
      end
      S_MUL2: begin
        x_d   = (|dprod[63:36]) ? XMAX : dprod[35:16];
        acc_d = 33'h100000000;
        bit_d = 5'd19;
        st_d  = S_EXP;
      end
      S_EXP: begin
        // One factor of exp(-x) per bit of x, most significant bit first.
        if (x_q[bit_q]) begin
          acc_d = eprod[64:32];
        end
        if (bit_q == 5'd0) begin
          st_d = S_PROB;
        end else begin
          bit_d = bit_q - 5'd1;
        end
      end
      S_PROB: begin
        if (!dir_q) begin
          p1_d  = 17'h10000 - eround[32:16];
          dir_d = 1'b1;
          st_d  = S_DIST;
        end else begin
          p2_d = 17'h10000 - eround[32:16];
          st_d = S_FIN;
        end
      end
      S_FIN: begin
        res_d = fprod[32:16];
        st_d  = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || m_ready_i) begin
          ovalid_d = 1'b1;
          ostate_d = idx_q[2:0];
          oprob_d  = res_q;
          olast_d  = (idx_q + 4'd1 == cnt_q);
          if (idx_q + 4'd1 == cnt_q) begin
            st_d = S_IDLE;
          end else begin
            idx_d = idx_q + 4'd1;
            st_d  = S_READ;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      idx_q    <= 4'd0;
      dir_q    <= 1'b0;
      bit_q    <= 5'd0;
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      ovalid_q <= 1'b0;
      cnt_q    <= 4'd1;
    end else begin
      st_q     <= st_d;
      idx_q    <= idx_d;
      dir_q    <= dir_d;
      bit_q    <= bit_d;
      valid_q  <= valid_d;
      rvalid_q <= rvalid_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q  <= level_d;
    js_q     <= js_d;
    dist_q   <= dist_d;
    prod_q   <= prod_d;
    inten_q  <= inten_d;
    x_q      <= x_d;
    acc_q    <= acc_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    res_q    <= res_d;
    ostate_q <= ostate_d;
    oprob_q  <= oprob_d;
    olast_q  <= olast_d;
  end

  assign m_valid_o = ovalid_q;
  assign m_state_o = ostate_q;
  assign m_prob_o  = oprob_q;
  assign m_last_o  = olast_q;

  `PJTP_ASSERT(a_pop_idle, clk_i, rst_ni, q_pop_o |-> (st_q == S_IDLE))
  `PJTP_ASSERT(a_last_pos, clk_i, rst_ni,
               (ovalid_q && olast_q) |-> ({1'b0, ostate_q} + 4'd1 == cnt_q))
  `PJTP_ASSERT(a_exp_bit, clk_i, rst_ni, (st_q == S_EXP) |-> (bit_q <= 5'd19))

endmodule

// File: tb/poisson_jump_transition_prob_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poisson_jump_transition_prob_chk
// Watches both streams, predicts each result word and compares it.
// ----------------------------------------------------------------------------
// Load words update a private copy of the state tables. Each accepted observe
// word pushes one expected word per state in use; every accepted result word
// is checked against the oldest one. The register copy is written by the top
// through the cfg ports, which are snooped here as well.
// ----------------------------------------------------------------------------
module poisson_jump_transition_prob_chk
  import pjtp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [23:0]  m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           words_seen_o
);

  typedef struct packed {
    logic [2:0]  state;
    logic [16:0] prob;
    logic        last;
  } prob_word_t;

  logic [31:0] base_tbl [8];
  logic [31:0] slope_tbl [8];
  logic [31:0] thr_tbl [8];
  logic [31:0] delta_q;
  logic [3:0]  n_states;
  prob_word_t  expected_q [$];

  assign pending_o = expected_q.size();

  // exp(-x) by the bitwise product of exp(-2^k) factors, rounded to Q1.16.
  function automatic logic [16:0] exp_neg(input logic [63:0] x_in);
    logic [63:0] xs;
    logic [63:0] acc;
    logic [31:0] coef [20];
    coef = '{32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
             32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
             32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
             32'd4034748383, 32'd3790295335, 32'd3344923893, 32'd2605029347,
             32'd1580030169, 32'd581260616, 32'd78665070, 32'd1440801};
    xs  = (x_in > 64'hFFFFF) ? 64'hFFFFF : x_in;
    acc = 64'd1 << 32;
    for (int b = 19; b >= 0; b--) begin
      if (xs[b]) begin
        acc = ((acc * {32'd0, coef[b]}) + (64'd1 << 31)) >> 32;
      end
    end
    return 17'((acc + 64'd32768) >> 16);
  endfunction

  function automatic logic [16:0] jump_prob(input logic [31:0] base, input logic [31:0] slope,
                                            input longint diff);
    logic [63:0] distance;
    logic [95:0] inten;
    logic [95:0] x;
    distance = (diff > 0) ? 64'(diff) : 64'd0;
    inten    = 96'(base) + ((96'(slope) * 96'(distance)) >> 16);
    if (inten > 96'hFFFFFFFF) inten = 96'hFFFFFFFF;
    x = (96'(delta_q) * inten) >> 16;
    return 17'd65536 - exp_neg(x > 96'hFFFFF ? 64'hFFFFF : 64'(x));
  endfunction

  function automatic logic [16:0] q16_mul(input logic [16:0] a, input logic [16:0] b);
    logic [63:0] p;
    p = (64'(a) * 64'(b) + 64'd32768) >> 16;
    return 17'(p);
  endfunction

  task automatic predict_observation(input logic [31:0] level_w, input logic [31:0] jump_w);
    int          count;
    longint      level;
    longint      thr;
    logic [16:0] p1;
    logic [16:0] p2;
    prob_word_t  w;
    level = longint'($signed(level_w));
    count = (n_states == 0) ? 1 : ((n_states > 8) ? 8 : int'(n_states));
    for (int i = 0; i < count; i++) begin
      thr = longint'($signed(thr_tbl[i]));
      p1  = jump_prob(base_tbl[i], slope_tbl[i], thr - level);
      p2  = jump_prob(base_tbl[i], slope_tbl[i], level - thr);
      if ($signed(jump_w) > 0) w.prob = q16_mul(p1, 17'd65536 - p2);
      else if ($signed(jump_w) < 0) w.prob = q16_mul(p2, 17'd65536 - p1);
      else w.prob = q16_mul(17'd65536 - p1, 17'd65536 - p2);
      w.state = 3'(i);
      w.last  = (i + 1 == count);
      expected_q.push_back(w);
    end
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    prob_word_t got;
    prob_word_t exp_w;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        base_tbl[i]  <= '0;
        slope_tbl[i] <= '0;
        thr_tbl[i]   <= '0;
      end
      delta_q      <= 32'd65536;
      n_states     <= 4'd8;
      fail_count_o <= 0;
      words_seen_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_DELTA) delta_q <= cfg_wdata_i;
        else if (cfg_addr_i == REG_STATES) n_states <= cfg_wdata_i[3:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == CMD_LOAD) begin
          base_tbl[s_axis_tdata[2:0]]  <= s_axis_tdata[34:3];
          slope_tbl[s_axis_tdata[2:0]] <= s_axis_tdata[66:35];
          thr_tbl[s_axis_tdata[2:0]]   <= s_axis_tdata[98:67];
        end else begin
          predict_observation(s_axis_tdata[130:99], s_axis_tdata[162:131]);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        words_seen_o <= words_seen_o + 1;
        got.state = m_axis_tdata[2:0];
        got.prob  = m_axis_tdata[19:3];
        got.last  = m_axis_tlast;
        if (expected_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("ERROR: unexpected result word %p", got);
        end else begin
          exp_w = expected_q.pop_front();
          if (got !== exp_w) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10) begin
              $display("ERROR: state exp %0d got %0d, prob exp %0d got %0d, last exp %0b got %0b",
                       exp_w.state, got.state, exp_w.prob, got.prob, exp_w.last, got.last);
            end
          end
        end
      end
    end
  end

endmodule

// File: tb/poisson_jump_transition_prob_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poisson_jump_transition_prob_tb
// Stimulus and verdict for the jump transition probability block.
// ----------------------------------------------------------------------------
// Directed loads and observations cover the field extremes, all jump signs,
// saturation of the intensity and of exp, and out-of-range register values.
// Random phases then load and observe under several delta and state-count
// settings, with idling on both streams in three patterns.
// ----------------------------------------------------------------------------
module poisson_jump_transition_prob_tb;
  import pjtp_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_we_i = 1'b0;
  logic [0:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_wdata_i = '0;
  int           fail_count;
  int           pending;
  int           words_seen;
  int           send_idle_pct = 7;
  int           recv_idle_pct = 82;
  int           items_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  poisson_jump_transition_prob u_top (.*);

  poisson_jump_transition_prob_chk u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending), .words_seen_o(words_seen)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // The word stays valid after acceptance until the next word, an idle cycle
  // or a register write replaces it.
  task automatic send_word(input logic cmd, input logic [2:0] idx, input logic [31:0] a,
                           input logic [31:0] b, input logic [31:0] c,
                           input logic [31:0] level, input logic [31:0] jump);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {5'd0, jump, level, c, b, a, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic load(input logic [2:0] idx, input logic [31:0] base, input logic [31:0] slope,
                      input logic [31:0] thr);
    send_word(CMD_LOAD, idx, base, slope, thr, $urandom, $urandom);
  endtask

  task automatic observe(input logic [31:0] level, input logic [31:0] jump);
    send_word(CMD_OBSERVE, 3'($urandom), $urandom, $urandom, $urandom, level, jump);
  endtask

  // Registers are only written once all results are out and the datapath has
  // had time to finish a trailing load.
  task automatic write_reg(input logic [0:0] addr, input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h3_0000);
      2: return $urandom_range(32'h1000);
      default: return 32'(0);
    endcase
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0) begin
        load(3'($urandom), rand_rate(), rand_rate(),
             $urandom_range(1) ? $urandom : 32'($signed($urandom_range(32'h8_0000)) - 32'sh4_0000));
      end else begin
        observe($urandom_range(1) ? $urandom
                                  : 32'($signed($urandom_range(32'h8_0000)) - 32'sh4_0000),
                $urandom_range(2) == 0 ? 32'd0 : $urandom);
      end
    end
  endtask

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zeroed tables after reset, with all three jump signs.
    observe(32'h0, 32'h0);
    observe(32'h7FFFFFFF, 32'h1);
    observe(32'h80000000, 32'h80000000);
    load(3'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF);
    load(3'd1, 32'h0, 32'hFFFFFFFF, 32'h80000000);
    load(3'd2, 32'h0001_0000, 32'h0, 32'h0);
    load(3'd3, 32'h0000_4000, 32'h0000_8000, 32'h0002_0000);
    load(3'd7, 32'h0, 32'h0, 32'hFFFF_0000);
    observe(32'h80000000, 32'h7FFFFFFF);
    observe(32'h7FFFFFFF, 32'hFFFFFFFF);
    observe(32'h0001_0000, 32'h0);
    write_reg(REG_STATES, 32'd0);
    observe(32'h0, 32'h5);
    write_reg(REG_STATES, 32'd15);
    write_reg(REG_DELTA, 32'd0);
    observe(32'h1234_5678, 32'h1);
    write_reg(REG_DELTA, 32'hFFFFFFFF);
    observe(32'h0, 32'hFFFFFFFF);
    observe(32'hFFFF_0000, 32'h0);

    write_reg(REG_DELTA, 32'd65536);
    write_reg(REG_STATES, 32'd3);
    random_phase(90);
    send_idle_pct = 82;
    recv_idle_pct = 7;
    write_reg(REG_DELTA, 32'h0000_0400);
    write_reg(REG_STATES, 32'd1);
    random_phase(60);
    write_reg(REG_STATES, 32'd8);
    write_reg(REG_DELTA, 32'h0004_0000);
    random_phase(60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_DELTA, $urandom);
    write_reg(REG_STATES, 32'd5);
    random_phase(50);
    write_reg(REG_DELTA, 32'd65536);
    write_reg(REG_STATES, 32'd8);
    random_phase(50);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    $display("Sent %0d words and checked %0d result words", items_sent, words_seen);
    $display("across five delta and state-count settings with three idling patterns.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: poisson_jump_transition_prob.f
+incdir+hw/rtl
hw/rtl/pjtp_pkg.sv
hw/rtl/pjtp_ram.sv
hw/rtl/pjtp_front.sv
hw/rtl/pjtp_queue.sv
hw/rtl/pjtp_back.sv
hw/rtl/poisson_jump_transition_prob.sv
tb/poisson_jump_transition_prob_chk.sv
tb/poisson_jump_transition_prob_tb.sv
